[hdl/msma_pkg.sv]
// Shared types and constants for the median/sum mix aggregator.
// No dependencies; used by msma_regs and the top level.
package msma_pkg;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    localparam logic [0:0] REG_WORKER_COUNT = 1'b0;
    localparam logic [0:0] REG_MIX_WEIGHT   = 1'b1;

    localparam logic [4:0]  WORKER_COUNT_RST = 5'd1;
    localparam logic [16:0] MIX_WEIGHT_RST   = 17'd0;
    localparam logic [16:0] WEIGHT_ONE       = 17'h10000;
    localparam int          MIX_SHIFT        = 17;

    typedef struct packed {
        logic [4:0]  worker_count;
        logic [16:0] mix_weight;
    } t_cfg;

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_SHIFT = 12'b0000_0000_0010,
        ST_PLACE = 12'b0000_0000_0100,
        ST_RD_LO = 12'b0000_0000_1000,
        ST_RD_HI = 12'b0000_0001_0000,
        ST_SUM   = 12'b0000_0010_0000,
        ST_MIX_A = 12'b0000_0100_0000,
        ST_MIX_B = 12'b0000_1000_0000,
        ST_MIX_C = 12'b0001_0000_0000,
        ST_MIX_D = 12'b0010_0000_0000,
        ST_ROUND = 12'b0100_0000_0000,
        ST_OUT   = 12'b1000_0000_0000
    } t_state;

endpackage

[hdl/msma_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module msma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/msma_mul.sv]
// Shared signed-by-unsigned multiplier with a product register.
// No dependencies; sequenced by the top level.
module msma_mul #(
    parameter int AW = 37,
    parameter int BW = 22
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [AW-1:0]    i_a,
    input  logic [BW-1:0]           i_b,
    output logic signed [AW+BW:0]   o_prod
);

    localparam int PW = AW + BW + 1;

    logic signed [PW-1:0] mul_a;
    logic signed [PW-1:0] mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [PW-1:0] r_prod;

    assign mul_a = PW'(i_a);
    assign mul_b = $signed({{(AW + 1){1'b0}}, i_b});
    assign mul_p = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= mul_p;
        end
    end

    assign o_prod = r_prod;

endmodule

[hdl/msma_regs.sv]
// APB configuration registers: worker_count and mix_weight.
// Depends on msma_pkg.
module msma_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [msma_pkg::CFG_AW-1:0]  paddr,
    input  logic [msma_pkg::CFG_DW-1:0]  pwdata,
    output logic [msma_pkg::CFG_DW-1:0]  prdata,
    output logic                         pready,
    output msma_pkg::t_cfg               o_cfg
);

    msma_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [0:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.worker_count <= msma_pkg::WORKER_COUNT_RST;
            r_cfg.mix_weight   <= msma_pkg::MIX_WEIGHT_RST;
        end else if (wr_en) begin
            case (reg_idx)
                msma_pkg::REG_WORKER_COUNT: r_cfg.worker_count <= pwdata[4:0];
                msma_pkg::REG_MIX_WEIGHT:   r_cfg.mix_weight   <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            msma_pkg::REG_WORKER_COUNT: prdata = 32'(r_cfg.worker_count);
            msma_pkg::REG_MIX_WEIGHT:   prdata = 32'(r_cfg.mix_weight);
            default:                    prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[hdl/median_sum_mix_aggregator.sv]
// Top level: per-coordinate mix of worker sum and median, one shared multiplier.
// Depends on msma_pkg, msma_ram, msma_mul, msma_regs.
//
// Worker values enter one per start beat while busy is low. Each value is
// insertion-sorted into a small RAM: the single RAM read/compare/write loop
// shifts each earlier value of the coordinate that is larger up one slot,
// then places the value. The value that completes a coordinate then passes
// through two median reads, their sum, and the mix done as three passes
// through one multiplier, an add, a rounding step and saturation. The result
// beat is shown on o_result_valid for one cycle, in the cycle busy drops, and
// cannot be stalled; a new start may be taken in that same cycle.
module median_sum_mix_aggregator #(
    parameter int MAX_WORKERS   = 16,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [msma_pkg::CFG_AW-1:0]  paddr,
    input  logic [msma_pkg::CFG_DW-1:0]  pwdata,
    output logic [msma_pkg::CFG_DW-1:0]  prdata,
    output logic                         pready,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [31:0]           i_worker_value,
    input  logic                         i_end_of_vector,
    output logic                         o_result_valid,
    output logic signed [31:0]           o_aggregate,
    output logic                         o_clipped,
    output logic                         o_vector_done
);

    localparam int E    = ELEMENT_WIDTH;
    localparam int AD   = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int CW   = $clog2(MAX_WORKERS + 1);
    localparam int TW   = E + AD;
    localparam int AW   = TW + 1;
    localparam int BW   = 17 + CW;
    localparam int PW   = AW + BW + 1;
    localparam int ACCW = PW + 2;
    localparam int QW   = ACCW - msma_pkg::MIX_SHIFT;
    localparam longint ROUND_ADD = (64'sd1 <<< msma_pkg::MIX_SHIFT) - 64'sd1;
    localparam logic signed [QW-1:0] Q_HI = QW'((64'sd1 <<< (E - 1)) - 64'sd1);
    localparam logic signed [QW-1:0] Q_LO = -Q_HI - QW'(1);

    msma_pkg::t_cfg   cfg;
    msma_pkg::t_state r_state, n_state;

    logic [CW-1:0]          r_count, n_count;
    logic signed [TW-1:0]   r_total, n_total;
    logic                   r_end, n_end;
    logic signed [E-1:0]    r_key, n_key;
    logic [AD-1:0]          r_j, n_j;
    logic signed [E-1:0]    r_mid_a, n_mid_a;
    logic signed [E:0]      r_m2, n_m2;
    logic signed [ACCW-1:0] r_acc, n_acc;
    logic                   r_valid, n_valid;
    logic signed [31:0]     r_agg, n_agg;
    logic                   r_clip, n_clip;
    logic                   r_vdone, n_vdone;

    logic                   ram_we;
    logic [AD-1:0]          ram_waddr;
    logic [E-1:0]           ram_wdata;
    logic [AD-1:0]          ram_raddr;
    logic [E-1:0]           ram_rdata;

    logic                   mul_en;
    logic signed [AW-1:0]   mul_a;
    logic [BW-1:0]          mul_b;
    logic signed [PW-1:0]   mul_p;

    logic [CW-1:0]          n_eff;
    logic [16:0]            w_eff;
    logic [CW-1:0]          half;
    logic [AD-1:0]          lo_addr;
    logic [AD-1:0]          hi_addr;
    logic signed [E-1:0]    in_val;
    logic signed [QW-1:0]   q;
    logic signed [E-1:0]    q_sat;
    logic                   q_clip;
    msma_pkg::t_state       placed_st;

    msma_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    msma_ram #(
        .WIDTH (E),
        .DEPTH (MAX_WORKERS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    msma_mul #(
        .AW (AW),
        .BW (BW)
    ) u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_p)
    );

    always_comb begin
        if (cfg.worker_count == 5'd0) begin
            n_eff = CW'(1);
        end else if (int'(cfg.worker_count) > MAX_WORKERS) begin
            n_eff = CW'(MAX_WORKERS);
        end else begin
            n_eff = CW'(cfg.worker_count);
        end
        w_eff = (cfg.mix_weight > msma_pkg::WEIGHT_ONE) ? msma_pkg::WEIGHT_ONE
                                                        : cfg.mix_weight;
    end

    assign half    = r_count >> 1;
    assign hi_addr = AD'(half);
    assign lo_addr = r_count[0] ? AD'(half) : AD'(half - CW'(1));
    assign in_val  = $signed(i_worker_value[E-1:0]);
    assign busy    = (r_state != msma_pkg::ST_IDLE);

    assign placed_st = (r_count >= n_eff) ? msma_pkg::ST_RD_LO : msma_pkg::ST_IDLE;

    assign q      = QW'(r_acc >>> msma_pkg::MIX_SHIFT);
    assign q_clip = (q > Q_HI) || (q < Q_LO);
    assign q_sat  = (q > Q_HI) ? E'(Q_HI) : ((q < Q_LO) ? E'(Q_LO) : E'(q));

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_total   = r_total;
        n_end     = r_end;
        n_key     = r_key;
        n_j       = r_j;
        n_mid_a   = r_mid_a;
        n_m2      = r_m2;
        n_acc     = r_acc;
        n_valid   = 1'b0;
        n_agg     = r_agg;
        n_clip    = r_clip;
        n_vdone   = r_vdone;
        ram_we    = 1'b0;
        ram_waddr = r_j;
        ram_wdata = r_key;
        ram_raddr = '0;
        mul_en    = 1'b0;
        mul_a     = '0;
        mul_b     = '0;

        case (r_state)
            msma_pkg::ST_IDLE: begin
                if (start) begin
                    n_key     = in_val;
                    n_total   = r_total + TW'(in_val);
                    n_end     = r_end | i_end_of_vector;
                    n_count   = r_count + CW'(1);
                    n_j       = r_count[AD-1:0];
                    ram_raddr = AD'(r_count - CW'(1));
                    n_state   = (r_count == '0) ? msma_pkg::ST_PLACE : msma_pkg::ST_SHIFT;
                end
            end
            msma_pkg::ST_SHIFT: begin
                ram_we = 1'b1;
                if ($signed(ram_rdata) > r_key) begin
                    ram_wdata = ram_rdata;
                    n_j       = r_j - AD'(1);
                    ram_raddr = r_j - AD'(2);
                    if (r_j == AD'(1)) begin
                        n_state = msma_pkg::ST_PLACE;
                    end
                end else begin
                    n_state = placed_st;
                end
            end
            msma_pkg::ST_PLACE: begin
                ram_we  = 1'b1;
                n_state = placed_st;
            end
            msma_pkg::ST_RD_LO: begin
                ram_raddr = lo_addr;
                n_state   = msma_pkg::ST_RD_HI;
            end
            msma_pkg::ST_RD_HI: begin
                ram_raddr = hi_addr;
                n_mid_a   = $signed(ram_rdata);
                n_state   = msma_pkg::ST_SUM;
            end
            msma_pkg::ST_SUM: begin
                n_m2    = (E + 1)'(r_mid_a) + (E + 1)'($signed(ram_rdata));
                n_state = msma_pkg::ST_MIX_A;
            end
            msma_pkg::ST_MIX_A: begin
                // (1 - w) * S
                mul_en  = 1'b1;
                mul_a   = AW'(r_total);
                mul_b   = BW'(17'(msma_pkg::WEIGHT_ONE - w_eff));
                n_state = msma_pkg::ST_MIX_B;
            end
            msma_pkg::ST_MIX_B: begin
                mul_en  = 1'b1;
                n_acc   = ACCW'(mul_p) <<< 1;
                mul_a   = $signed(AW'(r_count));
                mul_b   = BW'(w_eff);
                n_state = msma_pkg::ST_MIX_C;
            end
            msma_pkg::ST_MIX_C: begin
                // (w * N) * M2
                mul_en  = 1'b1;
                mul_a   = AW'(r_m2);
                mul_b   = mul_p[BW-1:0];
                n_state = msma_pkg::ST_MIX_D;
            end
            msma_pkg::ST_MIX_D: begin
                n_acc   = r_acc + ACCW'(mul_p);
                n_state = msma_pkg::ST_ROUND;
            end
            msma_pkg::ST_ROUND: begin
                // bias negatives so the shift truncates toward zero
                if (r_acc[ACCW-1]) begin
                    n_acc = r_acc + ACCW'(ROUND_ADD);
                end
                n_state = msma_pkg::ST_OUT;
            end
            msma_pkg::ST_OUT: begin
                n_valid = 1'b1;
                n_agg   = 32'(q_sat);
                n_clip  = q_clip;
                n_vdone = r_end;
                n_count = '0;
                n_total = '0;
                n_end   = 1'b0;
                n_state = msma_pkg::ST_IDLE;
            end
            default: begin
                n_state = msma_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msma_pkg::ST_IDLE;
            r_count <= '0;
            r_total <= '0;
            r_end   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_total <= n_total;
            r_end   <= n_end;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_j     <= n_j;
        r_mid_a <= n_mid_a;
        r_m2    <= n_m2;
        r_acc   <= n_acc;
        r_agg   <= n_agg;
        r_clip  <= n_clip;
        r_vdone <= n_vdone;
    end

    assign o_result_valid = r_valid;
    assign o_aggregate    = r_agg;
    assign o_clipped      = r_clip;
    assign o_vector_done  = r_vdone;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_result_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (r_count == '0 && !r_end && !busy))
        else $error("coordinate state not cleared with result");

    a_result_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= MAX_WORKERS)
        else $error("arrival count beyond store depth");

    a_shift_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == msma_pkg::ST_SHIFT) |-> (r_j != '0))
        else $error("insertion shift at slot zero");

endmodule
